FILE: rtl/core/tcw_pkg.sv
package tcw_pkg;

   // field widths of the channels
   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int RADDR_W = 11;
   localparam int CELL_W  = 16;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int OFS_W   = 11;
   localparam int COLOR_W = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
   localparam logic [CELL_W-1:0]  CELL_RESET  = {COLOR_RESET, CH_SPACE};

endpackage

FILE: rtl/core/tcw_if.sv
interface tcw_req_if;
   logic                         valid;
   logic                         ready;
   logic [tcw_pkg::OP_W-1:0]     op;
   logic [tcw_pkg::CHAR_W-1:0]   char_code;
   logic [tcw_pkg::RADDR_W-1:0]  read_address;

   modport source (output valid, op, char_code, read_address, input ready);
   modport sink   (input valid, op, char_code, read_address, output ready);
endinterface

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::CELL_W-1:0]    cell_data;
   logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row;
   logic [tcw_pkg::COL_OUT_W-1:0] cursor_col;
   logic [tcw_pkg::OFS_W-1:0]     cursor_offset;
   logic                          scrolled;

   modport source (output valid, cell_data, cursor_row, cursor_col, cursor_offset, scrolled,
                   input ready);
   modport sink   (input valid, cell_data, cursor_row, cursor_col, cursor_offset, scrolled,
                   output ready);
endinterface

interface tcw_csr_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::COLOR_W-1:0] text_color;

   modport source (output valid, text_color, input ready);
   modport sink   (input valid, text_color, output ready);
endinterface

FILE: rtl/core/text_console_writer_unit.sv
// Text-mode console engine. It holds a ROWS x COLUMNS screen of 16-bit cells (attribute
// byte high, character low) in a single-port RAM plus a cursor, and answers every request
// transaction with exactly one response transaction carrying the cursor after the request.
// Op 0 interprets one byte (LF, CR, BS, TAB move the cursor; 0x20-0x7F is stored with the
// current color; anything else is ignored), op 1 blanks the screen and homes the cursor,
// op 2 reads one cell. One request is in flight at a time; the response sits in an output
// register so the next request is taken while it waits. All work goes through the one RAM
// port and the shared address counter that walks it; a byte that scrolls moves the
// screen up one row (a read and a write per moved cell, then one write per blanked cell).
// After reset the block runs a clearing pass over every cell, during which it takes no
// request; color writes on the csr channel are taken at any time.
module text_console_writer_unit #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   tcw_req_if.sink   req_bus,
   tcw_rsp_if.source rsp_bus,
   tcw_csr_if.sink   csr_bus
);

   localparam int CELLS     = ROWS * COLUMNS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int ROW_W     = $clog2(ROWS + 1);
   localparam int COL_W     = $clog2(COLUMNS + TAB_WIDTH);
   localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;

   // sequencer codes
   localparam logic [3:0] S_INIT = 4'd0;  // clearing pass after reset
   localparam logic [3:0] S_IDLE = 4'd1;  // waiting for a request
   localparam logic [3:0] S_TAB  = 4'd2;  // step tab stop until past the cursor
   localparam logic [3:0] S_ADJ  = 4'd3;  // column wrap and scroll decision
   localparam logic [3:0] S_SRD  = 4'd4;  // scroll: read the cell one row below
   localparam logic [3:0] S_SWR  = 4'd5;  // scroll: write it one row up
   localparam logic [3:0] S_FILL = 4'd6;  // write blanks up to the last cell
   localparam logic [3:0] S_RD   = 4'd7;  // take the read data
   localparam logic [3:0] S_DONE = 4'd8;  // hand over the response

   logic [3:0]                    state_ff, state_in;
   logic [ADDR_W-1:0]             addr_ff, addr_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [COL_W-1:0]              stop_ff, stop_in;
   logic [tcw_pkg::COLOR_W-1:0]   color_ff, color_in;
   logic                          scroll_ff, scroll_in;
   logic [tcw_pkg::CELL_W-1:0]    cell_ff, cell_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;
   logic [tcw_pkg::ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::OFS_W-1:0]     rsp_ofs_ff, rsp_ofs_in;
   logic                          rsp_scroll_ff, rsp_scroll_in;

   logic                          ram_en, ram_we;
   logic [ADDR_W-1:0]             ram_addr;
   logic [tcw_pkg::CELL_W-1:0]    ram_wr_data, ram_rd_data_ff;

   logic                          req_accept;
   logic [ADDR_W-1:0]             cur_lin;
   logic [ROW_W-1:0]              row_step;
   logic [tcw_pkg::CELL_W-1:0]    blank_cell;
   logic                          read_in_range;

   tcw_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W),
      .DATA_W (tcw_pkg::CELL_W)
   ) u_screen (
      .clock      (clock),
      .en         (ram_en),
      .we         (ram_we),
      .addr       (ram_addr),
      .wr_data    (ram_wr_data),
      .rd_data_ff (ram_rd_data_ff)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.cell_data     = rsp_cell_ff;
   assign rsp_bus.cursor_row    = rsp_row_ff;
   assign rsp_bus.cursor_col    = rsp_col_ff;
   assign rsp_bus.cursor_offset = rsp_ofs_ff;
   assign rsp_bus.scrolled      = rsp_scroll_ff;

   // linear cell index of the cursor; only used while the row is on screen
   assign cur_lin = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff));
   assign blank_cell = {color_ff, tcw_pkg::CH_SPACE};
   assign read_in_range = (32'(req_bus.read_address) < 32'(CELLS));

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      stop_in       = stop_ff;
      scroll_in     = scroll_ff;
      cell_in       = cell_ff;
      color_in      = color_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_ofs_in    = rsp_ofs_ff;
      rsp_scroll_in = rsp_scroll_ff;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = addr_ff;
      ram_wr_data   = blank_cell;
      row_step      = row_ff;

      // color register: taken whenever written
      if (csr_bus.valid) begin
         color_in = csr_bus.text_color;
      end

      // drop the response once the sink takes it
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            ram_en      = 1'b1;
            ram_we      = 1'b1;
            ram_wr_data = tcw_pkg::CELL_RESET;
            addr_in     = ADDR_W'(addr_ff + 1'b1);
            if (addr_ff == ADDR_W'(CELLS - 1)) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               scroll_in = 1'b0;
               cell_in   = '0;
               state_in  = S_DONE;
               case (req_bus.op)
                  tcw_pkg::OP_PUT: begin
                     state_in = S_ADJ;
                     case (req_bus.char_code) inside
                        tcw_pkg::CH_LF: begin
                           row_in = ROW_W'(row_ff + 1'b1);
                           col_in = '0;
                        end
                        tcw_pkg::CH_CR: begin
                           col_in = '0;
                        end
                        tcw_pkg::CH_BS: begin
                           if (col_ff != '0) begin
                              col_in = COL_W'(col_ff - 1'b1);
                           end
                        end
                        tcw_pkg::CH_TAB: begin
                           stop_in  = '0;
                           state_in = S_TAB;
                        end
                        [tcw_pkg::CH_SPACE:tcw_pkg::CH_LAST]: begin
                           ram_en      = 1'b1;
                           ram_we      = 1'b1;
                           ram_addr    = cur_lin;
                           ram_wr_data = {color_ff, req_bus.char_code};
                           col_in      = COL_W'(col_ff + 1'b1);
                        end
                        default: begin
                           state_in = S_DONE;
                        end
                     endcase
                  end
                  tcw_pkg::OP_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     addr_in  = '0;
                     state_in = S_FILL;
                  end
                  tcw_pkg::OP_READ: begin
                     if (read_in_range) begin
                        ram_en   = 1'b1;
                        ram_addr = ADDR_W'(req_bus.read_address);
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_TAB: begin
            // advance the stop one tab width a cycle until it passes the cursor
            if (stop_ff > col_ff) begin
               col_in   = stop_ff;
               state_in = S_ADJ;
            end else begin
               stop_in = COL_W'(stop_ff + COL_W'(TAB_WIDTH));
            end
         end

         S_ADJ: begin
            if (col_ff >= COL_W'(COLUMNS)) begin
               col_in   = '0;
               row_step = ROW_W'(row_ff + 1'b1);
            end
            if (row_step >= ROW_W'(ROWS)) begin
               row_in    = ROW_W'(ROWS - 1);
               scroll_in = 1'b1;
               addr_in   = '0;
               state_in  = S_SRD;
            end else begin
               row_in   = row_step;
               state_in = S_DONE;
            end
         end

         S_SRD: begin
            ram_en   = 1'b1;
            ram_addr = ADDR_W'(addr_ff + ADDR_W'(COLUMNS));
            state_in = S_SWR;
         end

         S_SWR: begin
            ram_en      = 1'b1;
            ram_we      = 1'b1;
            ram_wr_data = ram_rd_data_ff;
            addr_in     = ADDR_W'(addr_ff + 1'b1);
            // after the last moved cell the counter already points at the bottom row
            state_in    = (addr_ff == ADDR_W'(COPY_LAST)) ? S_FILL : S_SRD;
         end

         S_FILL: begin
            ram_en  = 1'b1;
            ram_we  = 1'b1;
            addr_in = ADDR_W'(addr_ff + 1'b1);
            if (addr_ff == ADDR_W'(CELLS - 1)) begin
               addr_in  = '0;
               state_in = S_DONE;
            end
         end

         S_RD: begin
            cell_in  = ram_rd_data_ff;
            state_in = S_DONE;
         end

         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = cell_ff;
               rsp_row_in    = tcw_pkg::ROW_OUT_W'(row_ff);
               rsp_col_in    = tcw_pkg::COL_OUT_W'(col_ff);
               rsp_ofs_in    = tcw_pkg::OFS_W'(cur_lin);
               rsp_scroll_in = scroll_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         color_ff     <= tcw_pkg::COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stop_ff       <= stop_in;
      scroll_ff     <= scroll_in;
      cell_ff       <= cell_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_ofs_ff    <= rsp_ofs_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   // no request is taken while the clearing pass runs
   a_init_blocks: assert property (@(posedge clock) $fell(reset) |-> !req_bus.ready)
      else $error("request channel ready during clearing pass");

   // between requests the cursor is always on screen
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> (row_ff < ROW_W'(ROWS)) && (col_ff < COL_W'(COLUMNS)))
      else $error("cursor off screen while idle");

   // a scroll always leaves the cursor on the bottom row
   a_scroll_bottom: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.scrolled |->
         rsp_bus.cursor_row == tcw_pkg::ROW_OUT_W'(ROWS - 1))
      else $error("scrolled response not on bottom row");

   // an accepted request always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != S_IDLE)
      else $error("accepted request did not start work");

endmodule

FILE: rtl/core/tcw_ram.sv
module tcw_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

endmodule

FILE: dv/text_console_writer_unit_test.sv
`timescale 1ns / 1ps
module text_console_writer_unit_test;

   // Screen geometry of the build under test
   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int TAB_W = 8;
   localparam int CELLS = COLS * ROWS;

   // Op 3 has no meaning; the block must leave everything alone
   localparam logic [tcw_pkg::OP_W-1:0] OP_NONE = 2'd3;

   localparam int ITEMS_PER_PHASE = 300;
   localparam int TAIL_CYCLES     = 50;
   localparam int MAX_REPORTS     = 10;
   localparam int LONG_HOLD       = 600;

   typedef struct packed {
      logic [tcw_pkg::CELL_W-1:0]    cell_data;
      logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row;
      logic [tcw_pkg::COL_OUT_W-1:0] cursor_col;
      logic [tcw_pkg::OFS_W-1:0]     cursor_offset;
      logic                          scrolled;
   } console_rsp_type;

   // One line of the directed script. A hand-checked line carries its response;
   // every other line is checked against the shadow console.
   typedef struct packed {
      logic [tcw_pkg::OP_W-1:0]    op;
      logic [tcw_pkg::CHAR_W-1:0]  char_code;
      logic [tcw_pkg::RADDR_W-1:0] read_address;
      logic [5:0]                  repeats;
      logic                        hand_checked;
      console_rsp_type             hand_rsp;
   } script_row_type;

   localparam console_rsp_type NO_RSP     = '0;
   localparam console_rsp_type HOME_BLANK = '{tcw_pkg::CELL_RESET, 5'd0, 7'd0, 11'd0, 1'b0};
   localparam console_rsp_type HOME_ZERO  = '{16'h0000, 5'd0, 7'd0, 11'd0, 1'b0};

   localparam int N_SCRIPT = 23;
   localparam script_row_type SCRIPT [N_SCRIPT] = '{
      // fresh screen: first and last cell blank, cursor home
      '{tcw_pkg::OP_READ,  8'h00,             11'd0,    6'd1,  1'b1, HOME_BLANK},
      '{tcw_pkg::OP_READ,  8'h00,             11'd1999, 6'd1,  1'b1, HOME_BLANK},
      // address past the screen reads as zero
      '{tcw_pkg::OP_READ,  8'h00,             11'h7FF,  6'd1,  1'b1, HOME_ZERO},
      // unused op touches nothing
      '{OP_NONE,           8'hFF,             11'd5,    6'd1,  1'b1, HOME_ZERO},
      // printable extremes
      '{tcw_pkg::OP_PUT,   tcw_pkg::CH_SPACE, 11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_PUT,   tcw_pkg::CH_LAST,  11'd0,    6'd1,  1'b0, NO_RSP},
      // ignored bytes: low control, top of control range, high half
      '{tcw_pkg::OP_PUT,   8'h00,             11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_PUT,   8'h1F,             11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_PUT,   8'h80,             11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_PUT,   8'hFF,             11'd0,    6'd1,  1'b0, NO_RSP},
      // cursor moves: backspace, return, backspace stuck at column 0, tab
      '{tcw_pkg::OP_PUT,   tcw_pkg::CH_BS,    11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_PUT,   tcw_pkg::CH_CR,    11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_PUT,   tcw_pkg::CH_BS,    11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_PUT,   tcw_pkg::CH_TAB,   11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_READ,  8'h00,             11'd1,    6'd1,  1'b0, NO_RSP},
      // tabs run off the last column and wrap
      '{tcw_pkg::OP_PUT,   tcw_pkg::CH_TAB,   11'd0,    6'd9,  1'b0, NO_RSP},
      // walk down to the bottom row, mark it, then scroll
      '{tcw_pkg::OP_PUT,   tcw_pkg::CH_LF,    11'd0,    6'd23, 1'b0, NO_RSP},
      '{tcw_pkg::OP_PUT,   8'h41,             11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_PUT,   tcw_pkg::CH_LF,    11'd0,    6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_READ,  8'h00,             11'd1920, 6'd1,  1'b0, NO_RSP},
      '{tcw_pkg::OP_READ,  8'h00,             11'd1840, 6'd1,  1'b0, NO_RSP},
      // clear homes the cursor and blanks with the reset color
      '{tcw_pkg::OP_CLEAR, 8'h00,             11'd0,    6'd1,  1'b1, HOME_ZERO},
      '{tcw_pkg::OP_READ,  8'h00,             11'd0,    6'd1,  1'b1, HOME_BLANK}
   };

   logic clock;
   logic reset;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();
   tcw_csr_if csr_bus ();

   text_console_writer_unit #(
      .COLUMNS   (COLS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_W)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the console: screen, cursor and color
   logic [tcw_pkg::CELL_W-1:0]  shadow_screen [CELLS];
   int unsigned                 shadow_row;
   int unsigned                 shadow_col;
   logic [tcw_pkg::COLOR_W-1:0] shadow_color;

   console_rsp_type awaited_rsp_q [$];
   int              errors;
   int unsigned     send_idle_pct;
   int unsigned     rsp_stall_pct;
   int              rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Apply one transaction to the shadow console and return the response it must produce
   function automatic console_rsp_type apply_console_op(
      input logic [tcw_pkg::OP_W-1:0]    op,
      input logic [tcw_pkg::CHAR_W-1:0]  ch,
      input logic [tcw_pkg::RADDR_W-1:0] addr);
      console_rsp_type r;
      r = '0;
      case (op)
         tcw_pkg::OP_PUT: begin
            if (ch == tcw_pkg::CH_LF) begin
               shadow_row++;
               shadow_col = 0;
            end else if (ch == tcw_pkg::CH_BS) begin
               if (shadow_col != 0) shadow_col--;
            end else if (ch == tcw_pkg::CH_TAB) begin
               shadow_col = shadow_col - (shadow_col % TAB_W) + TAB_W;
            end else if (ch == tcw_pkg::CH_CR) begin
               shadow_col = 0;
            end else if (ch >= tcw_pkg::CH_SPACE && ch <= tcw_pkg::CH_LAST) begin
               shadow_screen[shadow_row * COLS + shadow_col] = {shadow_color, ch};
               shadow_col++;
            end
            // wrap past the last column
            if (shadow_col >= COLS) begin
               shadow_col = 0;
               shadow_row++;
            end
            // scroll up one row past the bottom, blank the new bottom row
            if (shadow_row >= ROWS) begin
               for (int i = 0; i < (ROWS - 1) * COLS; i++)
                  shadow_screen[i] = shadow_screen[i + COLS];
               for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
                  shadow_screen[i] = {shadow_color, tcw_pkg::CH_SPACE};
               shadow_row = ROWS - 1;
               r.scrolled = 1'b1;
            end
         end
         tcw_pkg::OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               shadow_screen[i] = {shadow_color, tcw_pkg::CH_SPACE};
            shadow_row = 0;
            shadow_col = 0;
         end
         tcw_pkg::OP_READ: begin
            if (addr < CELLS) r.cell_data = shadow_screen[addr];
         end
         default: ;
      endcase
      r.cursor_row    = tcw_pkg::ROW_OUT_W'(shadow_row);
      r.cursor_col    = tcw_pkg::COL_OUT_W'(shadow_col);
      r.cursor_offset = tcw_pkg::OFS_W'(shadow_row * COLS + shadow_col);
      return r;
   endfunction

   // Offer one request transaction; record the awaited response once it is taken
   task automatic offer_request(input logic [tcw_pkg::OP_W-1:0]    op,
                                input logic [tcw_pkg::CHAR_W-1:0]  ch,
                                input logic [tcw_pkg::RADDR_W-1:0] addr,
                                input logic                        hand_checked,
                                input console_rsp_type             hand_rsp);
      console_rsp_type pred;
      // idle the sender while a random draw falls under send_idle_pct
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.char_code    <= ch;
      req_bus.read_address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      // valid stays high here; the next offer or a drain decides whether to drop it
      pred = apply_console_op(op, ch, addr);
      awaited_rsp_q.push_back(hand_checked ? hand_rsp : pred);
   endtask

   // Mostly text with the odd control byte; reads aim near the cursor so they
   // land on cells just written
   task automatic offer_random_request();
      int unsigned                 pick;
      int unsigned                 here;
      int unsigned                 back;
      logic [tcw_pkg::OP_W-1:0]    op;
      logic [tcw_pkg::CHAR_W-1:0]  ch;
      logic [tcw_pkg::RADDR_W-1:0] addr;
      pick = $urandom_range(999);
      op   = tcw_pkg::OP_PUT;
      ch   = tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_SPACE, tcw_pkg::CH_LAST));
      addr = tcw_pkg::RADDR_W'($urandom);
      if (pick < 560) begin
         // printable text, already set up
      end else if (pick < 620) begin
         ch = tcw_pkg::CH_LF;
      end else if (pick < 650) begin
         ch = tcw_pkg::CH_CR;
      end else if (pick < 690) begin
         ch = tcw_pkg::CH_BS;
      end else if (pick < 730) begin
         ch = tcw_pkg::CH_TAB;
      end else if (pick < 780) begin
         // ignored byte: control range or high half
         ch = ($urandom_range(1) == 0) ? tcw_pkg::CHAR_W'($urandom_range(8'h00, 8'h1F))
                                       : tcw_pkg::CHAR_W'($urandom_range(8'h80, 8'hFF));
      end else if (pick < 955) begin
         op   = tcw_pkg::OP_READ;
         here = shadow_row * COLS + shadow_col;
         back = $urandom_range(0, 100);
         if ($urandom_range(7) != 0)
            addr = tcw_pkg::RADDR_W'((here >= back) ? here - back : here);
      end else if (pick < 960) begin
         op = tcw_pkg::OP_CLEAR;
      end else if (pick < 970) begin
         op = OP_NONE;
         ch = tcw_pkg::CHAR_W'($urandom);
      end
      offer_request(op, ch, addr, 1'b0, NO_RSP);
   endtask

   // Drop valid and hold until every awaited response has arrived, then settle
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Write the color register; only called while the block is idle
   task automatic write_color(input logic [tcw_pkg::COLOR_W-1:0] color);
      csr_bus.valid      <= 1'b1;
      csr_bus.text_color <= color;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      shadow_color = color;
   endtask

   // Response side: check each accepted transaction, then pick ready for the next edge
   always @(posedge clock) begin
      console_rsp_type got;
      console_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.cell_data, rsp_bus.cursor_row, rsp_bus.cursor_col,
                 rsp_bus.cursor_offset, rsp_bus.scrolled};
         if (awaited_rsp_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected response: cell %h row %0d col %0d ofs %0d scrolled %0b",
                        got.cell_data, got.cursor_row, got.cursor_col, got.cursor_offset,
                        got.scrolled);
         end else begin
            want = awaited_rsp_q.pop_front();
            if (got.cell_data !== want.cell_data || got.cursor_row !== want.cursor_row ||
                got.cursor_col !== want.cursor_col ||
                got.cursor_offset !== want.cursor_offset || got.scrolled !== want.scrolled)
            begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $write("mismatch: exp cell %h row %0d col %0d ofs %0d scrolled %0b, ",
                         want.cell_data, want.cursor_row, want.cursor_col,
                         want.cursor_offset, want.scrolled);
                  $display("got cell %h row %0d col %0d ofs %0d scrolled %0b",
                           got.cell_data, got.cursor_row, got.cursor_col,
                           got.cursor_offset, got.scrolled);
               end
            end
         end
      end
      // a long hold-off wins over the random stall
      if (rsp_hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      logic [tcw_pkg::COLOR_W-1:0] color_pick;
      // drive every input to a known value before the first edge
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.op           = tcw_pkg::OP_PUT;
      req_bus.char_code    = '0;
      req_bus.read_address = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.text_color   = tcw_pkg::COLOR_RESET;
      rsp_bus.ready        = 1'b0;
      errors               = 0;
      send_idle_pct        = 0;
      rsp_stall_pct        = 0;
      rsp_hold_cycles      = 0;
      shadow_color         = tcw_pkg::COLOR_RESET;
      shadow_row           = 0;
      shadow_col           = 0;
      for (int i = 0; i < CELLS; i++) shadow_screen[i] = tcw_pkg::CELL_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed script at full rate; the clearing pass after reset just holds off ready
      foreach (SCRIPT[i]) begin
         for (int n = 0; n < SCRIPT[i].repeats; n++)
            offer_request(SCRIPT[i].op, SCRIPT[i].char_code, SCRIPT[i].read_address,
                          SCRIPT[i].hand_checked, SCRIPT[i].hand_rsp);
      end

      // Random phases, each under its own color and idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               color_pick    = 8'hFF;
            end
            1: begin
               send_idle_pct = 88;
               rsp_stall_pct = 0;
               color_pick    = 8'h00;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 88;
               color_pick    = tcw_pkg::COLOR_W'($urandom);
            end
            default: begin
               send_idle_pct = 38;
               rsp_stall_pct = 38;
               color_pick    = tcw_pkg::COLOR_W'($urandom);
            end
         endcase
         write_color(color_pick);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // back up the response side while requests keep coming
            if (phase == 0 && k == 100) rsp_hold_cycles = LONG_HOLD;
            // pause the sender until the block has answered everything
            if (phase == 0 && k == 200) drain_results();
            offer_random_request();
         end
      end

      drain_results();
      if (errors == 0 && awaited_rsp_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_ram.sv
rtl/core/text_console_writer_unit.sv
dv/text_console_writer_unit_test.sv
